// File: design/ffha_pkg.sv
package ffha_pkg;

   localparam int HEAP_BYTES_DEF   = 8192;
   localparam int ALIGN_BYTES_DEF  = 8;
   localparam int HEADER_BYTES_DEF = 8;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ALLOC_FAIL = 2'd1,
      STATUS_FREE_BAD   = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [12:0] request_bytes;
      logic [12:0] block_address;
   } req_type;

   typedef struct packed {
      logic [12:0] address;
      status_type  status;
      logic [12:0] free_bytes;
      logic [12:0] min_free_bytes;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_A_READ,
      ST_A_WAIT,
      ST_A_UNLINK,
      ST_F_READ,
      ST_F_WAIT,
      ST_I_START,
      ST_I_READ,
      ST_I_WAIT,
      ST_I_PREV,
      ST_I_NEXT,
      ST_I_WRITE,
      ST_I_LINK,
      ST_DONE,
      ST_A_FINAL,
      ST_RESP
   } state_type;

endpackage

// File: design/ffha_ram.sv
module ffha_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// File: design/first_fit_heap_allocator_top.sv
// channel   ports                       transaction when
// request   start, busy, req_item       start high and busy low at a rising edge
// response  rsp_strobe, rsp_item        rsp_strobe high, one cycle, always taken
//
// each header read on the free-list walks uses a read state and a wait state,
// since the header memory is single-port (one read or write per cycle)
// after reset busy stays high for a clearing pass that writes every header word
// busy stays high from acceptance through the response cycle
// the response cannot be stalled
module first_fit_heap_allocator_top
   import ffha_pkg::*;
#(
   parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
   parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int UNITS     = HEAP_BYTES / ALIGN_BYTES;
   localparam int AL        = $clog2(ALIGN_BYTES);
   localparam int HDR_UNITS = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int HDR_B     = HDR_UNITS * ALIGN_BYTES;
   localparam int END_UNIT  = UNITS - HDR_UNITS;
   localparam int UW        = $clog2(UNITS);
   localparam int CW        = $clog2(HEAP_BYTES + 1);
   localparam int EW        = 2 * UW + 1;
   localparam logic [UW-1:0] END_U = UW'(END_UNIT);

   state_type state_ff, state_in;
   func_type  op_ff, op_in;
   logic [12:0] req_ff, req_in, baddr_ff, baddr_in;
   logic [UW-1:0] want_ff, want_in;
   logic [UW-1:0] cur_ff, cur_in, prev_ff, prev_in, prev_size_ff, prev_size_in;
   logic prev_ok_ff, prev_ok_in;
   logic [UW-1:0] cur_size_ff, cur_size_in, cur_next_ff, cur_next_in;
   logic [UW-1:0] a_unit_ff, a_unit_in, a_size_ff, a_size_in, a_next_ff, a_next_in;
   logic [UW-1:0] b_ff, b_in, b_size_ff, b_size_in, b_next_ff, b_next_in;
   logic merged_ff, merged_in;
   logic [UW-1:0] head_ff, head_in, clr_ff, clr_in;
   logic [CW-1:0] free_ff, free_in, min_ff, min_in;
   logic [12:0] addr_ff, addr_in;
   status_type status_ff, status_in;

   logic          mem_we;
   logic [UW-1:0] mem_addr;
   logic [EW-1:0] mem_wdata, mem_rdata;
   logic [UW-1:0] rd_size, rd_next;
   logic          rd_used;

   logic [14:0] want_wide;
   logic [31:0] want_bytes, off;
   logic        alloc_bad, free_bad, split, prev_adj, next_adj, cur_before;
   logic [CW-1:0] free_sub;

   function automatic logic [UW-1:0] clamp(input logic [UW-1:0] v);
      return (v > END_U) ? END_U : v;
   endfunction

   function automatic logic [EW-1:0] pack(input logic used, input logic [UW-1:0] nxt,
                                          input logic [UW-1:0] sz);
      return {used, nxt, sz};
   endfunction

   ffha_ram #(.WIDTH(EW), .DEPTH(UNITS)) u_ram (
      .clock(clock), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
   );

   assign rd_size = mem_rdata[UW-1:0];
   assign rd_next = mem_rdata[2*UW-1:UW];
   assign rd_used = mem_rdata[2*UW];

   assign want_wide  = 15'(HDR_UNITS) + ((15'(req_ff) + 15'(ALIGN_BYTES - 1)) >> AL);
   assign want_bytes = 32'(want_wide) << AL;
   assign alloc_bad  = (req_ff == '0) || (want_bytes > 32'(free_ff));
   assign off        = 32'(baddr_ff) - 32'(HDR_B);
   assign free_bad   = (32'(baddr_ff) < 32'(HDR_B)) || (off[AL-1:0] != '0)
                       || ((off >> AL) >= 32'(END_UNIT));
   assign split      = (a_size_ff - want_ff) > UW'(2 * HDR_UNITS);
   assign prev_adj   = prev_ok_ff && ((UW+1)'(prev_ff) + (UW+1)'(prev_size_ff)
                                      == (UW+1)'(b_ff));
   assign next_adj   = ((UW+1)'(b_ff) + (UW+1)'(b_size_ff)) == (UW+1)'(cur_ff);
   assign cur_before = (cur_ff < b_ff) && (cur_ff < END_U);
   assign free_sub   = free_ff - CW'(32'(a_size_ff) << AL);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (clr_ff == UW'(UNITS - 1)) state_in = ST_IDLE;
         ST_IDLE:     if (start) state_in = ST_DECODE;
         ST_DECODE: begin
            if (op_ff == FUNC_ALLOC) state_in = alloc_bad ? ST_RESP : ST_A_READ;
            else state_in = free_bad ? ST_RESP : ST_F_READ;
         end
         ST_A_READ:   state_in = ST_A_WAIT;
         ST_A_WAIT: begin
            if (rd_size < want_ff && cur_ff != END_U) state_in = ST_A_READ;
            else if (cur_ff == END_U || rd_size < want_ff) state_in = ST_RESP;
            else state_in = ST_A_UNLINK;
         end
         ST_A_UNLINK: state_in = split ? ST_I_START : ST_A_FINAL;
         ST_F_READ:   state_in = ST_F_WAIT;
         ST_F_WAIT:   state_in = rd_used ? ST_I_START : ST_RESP;
         ST_I_START:  state_in = ST_I_READ;
         ST_I_READ:   state_in = ST_I_WAIT;
         ST_I_WAIT:   state_in = cur_before ? ST_I_READ : ST_I_PREV;
         ST_I_PREV:   state_in = ST_I_NEXT;
         ST_I_NEXT:   state_in = ST_I_WRITE;
         ST_I_WRITE:  state_in = (!merged_ff && prev_ok_ff) ? ST_I_LINK : ST_DONE;
         ST_I_LINK:   state_in = ST_DONE;
         ST_DONE:     state_in = (op_ff == FUNC_ALLOC) ? ST_A_FINAL : ST_RESP;
         ST_A_FINAL:  state_in = ST_RESP;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   // outputs and memory port
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = cur_ff;
      mem_wdata = '0;
      busy      = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_RESP);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            if (clr_ff == '0) mem_wdata = pack(1'b0, END_U, END_U);
            else if (clr_ff == END_U) mem_wdata = pack(1'b0, END_U, '0);
         end
         ST_A_UNLINK: begin
            mem_we    = prev_ok_ff;
            mem_addr  = prev_ff;
            mem_wdata = pack(1'b0, a_next_ff, prev_size_ff);
         end
         ST_I_PREV: begin
            mem_we   = prev_adj;
            mem_addr = b_ff;
         end
         ST_I_NEXT: begin
            mem_we   = next_adj && (cur_ff != END_U);
            mem_addr = cur_ff;
         end
         ST_I_WRITE: begin
            mem_we    = 1'b1;
            mem_addr  = b_ff;
            mem_wdata = pack(1'b0, b_next_ff, b_size_ff);
         end
         ST_I_LINK: begin
            mem_we    = 1'b1;
            mem_addr  = prev_ff;
            mem_wdata = pack(1'b0, b_ff, prev_size_ff);
         end
         ST_A_FINAL: begin
            mem_we    = 1'b1;
            mem_addr  = a_unit_ff;
            mem_wdata = pack(1'b1, END_U, a_size_ff);
         end
         default: ;
      endcase
      rsp_item.address        = addr_ff;
      rsp_item.status         = status_ff;
      rsp_item.free_bytes     = 13'(free_ff);
      rsp_item.min_free_bytes = 13'(min_ff);
   end

   // datapath
   always_comb begin
      op_in = op_ff;           req_in = req_ff;         baddr_in = baddr_ff;
      want_in = want_ff;       cur_in = cur_ff;         prev_in = prev_ff;
      prev_size_in = prev_size_ff;                      prev_ok_in = prev_ok_ff;
      cur_size_in = cur_size_ff;                        cur_next_in = cur_next_ff;
      a_unit_in = a_unit_ff;   a_size_in = a_size_ff;   a_next_in = a_next_ff;
      b_in = b_ff;             b_size_in = b_size_ff;   b_next_in = b_next_ff;
      merged_in = merged_ff;   head_in = head_ff;       clr_in = clr_ff;
      free_in = free_ff;       min_in = min_ff;
      addr_in = addr_ff;       status_in = status_ff;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         ST_IDLE: begin
            op_in    = req_item.func;
            req_in   = req_item.request_bytes;
            baddr_in = req_item.block_address;
         end
         ST_DECODE: begin
            addr_in    = '0;
            want_in    = want_wide[UW-1:0];
            prev_ok_in = 1'b0;
            if (op_ff == FUNC_ALLOC) begin
               status_in = STATUS_ALLOC_FAIL;
               cur_in    = clamp(head_ff);
            end else begin
               status_in = STATUS_FREE_BAD;
               cur_in    = UW'(off >> AL);
            end
         end
         ST_A_WAIT: begin
            if (rd_size < want_ff && cur_ff != END_U) begin
               prev_in      = cur_ff;
               prev_size_in = rd_size;
               prev_ok_in   = 1'b1;
               cur_in       = clamp(rd_next);
            end else begin
               a_unit_in = cur_ff;
               a_size_in = rd_size;
               a_next_in = clamp(rd_next);
            end
         end
         ST_A_UNLINK: begin
            if (!prev_ok_ff) head_in = a_next_ff;
            if (split) begin
               b_in      = a_unit_ff + want_ff;
               b_size_in = a_size_ff - want_ff;
               a_size_in = want_ff;
            end
         end
         ST_F_WAIT: begin
            if (rd_used) begin
               b_in      = cur_ff;
               b_size_in = rd_size;
               free_in   = free_ff + CW'(32'(rd_size) << AL);
               status_in = STATUS_OK;
            end
         end
         ST_I_START: begin
            cur_in     = clamp(head_ff);
            prev_ok_in = 1'b0;
         end
         ST_I_WAIT: begin
            if (cur_before) begin
               prev_in      = cur_ff;
               prev_size_in = rd_size;
               prev_ok_in   = 1'b1;
               cur_in       = clamp(rd_next);
            end else begin
               cur_size_in = rd_size;
               cur_next_in = clamp(rd_next);
            end
         end
         ST_I_PREV: begin
            merged_in = prev_adj;
            if (prev_adj) begin
               b_size_in = b_size_ff + prev_size_ff;
               b_in      = prev_ff;
            end
         end
         ST_I_NEXT: begin
            if (next_adj) begin
               if (cur_ff != END_U) begin
                  b_size_in = b_size_ff + cur_size_ff;
                  b_next_in = cur_next_ff;
               end else begin
                  b_next_in = END_U;
               end
            end else begin
               b_next_in = cur_ff;
            end
         end
         ST_I_WRITE: if (!merged_ff && !prev_ok_ff) head_in = b_ff;
         ST_A_FINAL: begin
            free_in   = free_sub;
            if (free_sub < min_ff) min_in = free_sub;
            addr_in   = 13'((32'(a_unit_ff) << AL) + 32'(HDR_B));
            status_in = STATUS_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         head_ff  <= '0;
         free_ff  <= CW'(END_UNIT * ALIGN_BYTES);
         min_ff   <= CW'(END_UNIT * ALIGN_BYTES);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         min_ff   <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;               req_ff <= req_in;           baddr_ff <= baddr_in;
      want_ff <= want_in;           cur_ff <= cur_in;           prev_ff <= prev_in;
      prev_size_ff <= prev_size_in; prev_ok_ff <= prev_ok_in;
      cur_size_ff <= cur_size_in;   cur_next_ff <= cur_next_in;
      a_unit_ff <= a_unit_in;       a_size_ff <= a_size_in;     a_next_ff <= a_next_in;
      b_ff <= b_in;                 b_size_ff <= b_size_in;     b_next_ff <= b_next_in;
      merged_ff <= merged_in;       addr_ff <= addr_in;         status_ff <= status_in;
   end

endmodule

// File: design/ffha_checker.sv
module ffha_checker
   import ffha_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("response strobe longer than one cycle");

   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("response while not busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted transaction did not set busy");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != STATUS_OK) |-> rsp_item.address == '0)
      else $error("nonzero address on failed transaction");

   a_min_free: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.min_free_bytes <= rsp_item.free_bytes)
      else $error("low-water mark above free count");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
);

// File: tb/sv/first_fit_heap_allocator_checker.sv
`timescale 1ns / 100ps

module first_fit_heap_allocator_checker
   import ffha_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      pending_count,
   output int      ok_allocs,
   output int      failed_allocs,
   output int      bad_frees,
   output int      good_frees
);

   localparam int UNITS     = HEAP_BYTES_DEF / ALIGN_BYTES_DEF;
   localparam int HDR_UNITS = (HEADER_BYTES_DEF + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF;
   localparam int HDR_BYTES = HDR_UNITS * ALIGN_BYTES_DEF;
   localparam int END_UNIT  = UNITS - HDR_UNITS;
   localparam int NO_LINK   = -1;

   int  blk_size [0:UNITS];
   int  blk_next [0:UNITS];
   bit  blk_used [0:UNITS];
   int  head_unit;
   int  free_count;
   int  low_water;
   rsp_type expected_q[$];

   function automatic int clamp_link(int v);
      return (v > END_UNIT || v < 0) ? END_UNIT : v;
   endfunction

   function automatic void clear_block(int u);
      blk_size[u] = 0;
      blk_next[u] = 0;
      blk_used[u] = 0;
   endfunction

   function automatic void link_free_block(int b);
      int prev;
      int cur;
      int n;
      prev = NO_LINK;
      cur = clamp_link(head_unit);
      n = 0;
      while (cur < b && cur < END_UNIT && n < UNITS) begin
         prev = cur;
         cur = clamp_link(blk_next[cur]);
         n++;
      end
      if (prev != NO_LINK && prev + blk_size[prev] == b) begin
         blk_size[prev] += blk_size[b];
         clear_block(b);
         b = prev;
      end
      if (b + blk_size[b] == cur) begin
         if (cur != END_UNIT) begin
            blk_size[b] += blk_size[cur];
            blk_next[b] = clamp_link(blk_next[cur]);
            clear_block(cur);
         end else begin
            blk_next[b] = END_UNIT;
         end
      end else begin
         blk_next[b] = cur;
      end
      if (prev != b) begin
         if (prev == NO_LINK) head_unit = b;
         else blk_next[prev] = b;
      end
   endfunction

   function automatic rsp_type heap_response(req_type r);
      rsp_type o;
      int want;
      int prev;
      int cur;
      int n;
      int off;
      int u;
      o.address = '0;
      o.status = STATUS_ALLOC_FAIL;
      if (r.func == FUNC_ALLOC) begin
         want = HDR_UNITS + (int'(r.request_bytes) + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF;
         if (r.request_bytes != 0 && want * ALIGN_BYTES_DEF <= free_count) begin
            prev = NO_LINK;
            cur = clamp_link(head_unit);
            n = 0;
            while (blk_size[cur] < want && cur != END_UNIT && n < UNITS) begin
               prev = cur;
               cur = clamp_link(blk_next[cur]);
               n++;
            end
            if (!(cur == END_UNIT || blk_size[cur] < want)) begin
               o.address = 13'(cur * ALIGN_BYTES_DEF + HDR_BYTES);
               if (prev == NO_LINK) head_unit = clamp_link(blk_next[cur]);
               else blk_next[prev] = clamp_link(blk_next[cur]);
               if (blk_size[cur] - want > 2 * HDR_UNITS) begin
                  blk_size[cur + want] = blk_size[cur] - want;
                  blk_used[cur + want] = 0;
                  blk_next[cur + want] = 0;
                  blk_size[cur] = want;
                  link_free_block(cur + want);
               end
               free_count -= blk_size[cur] * ALIGN_BYTES_DEF;
               if (free_count < low_water) low_water = free_count;
               blk_used[cur] = 1;
               blk_next[cur] = NO_LINK;
               o.status = STATUS_OK;
            end
         end
      end else begin
         o.status = STATUS_FREE_BAD;
         if (r.block_address >= HDR_BYTES) begin
            off = int'(r.block_address) - HDR_BYTES;
            u = off / ALIGN_BYTES_DEF;
            if (off % ALIGN_BYTES_DEF == 0 && u < END_UNIT && blk_used[u]) begin
               blk_used[u] = 0;
               free_count += blk_size[u] * ALIGN_BYTES_DEF;
               link_free_block(u);
               o.status = STATUS_OK;
            end
         end
      end
      o.free_bytes = 13'(free_count);
      o.min_free_bytes = 13'(low_water);
      return o;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      rsp_type want_rsp;
      rsp_type got_rsp;
      if (reset) begin
         for (int i = 0; i <= UNITS; i++) clear_block(i);
         blk_size[0] = END_UNIT;
         blk_next[0] = END_UNIT;
         blk_next[END_UNIT] = NO_LINK;
         head_unit = 0;
         free_count = END_UNIT * ALIGN_BYTES_DEF;
         low_water = free_count;
         expected_q.delete();
         fail_count <= 0;
         ok_allocs <= 0;
         failed_allocs <= 0;
         bad_frees <= 0;
         good_frees <= 0;
      end else begin
         if (rsp_strobe) begin
            got_rsp = rsp_item;
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %p", got_rsp);
               fail_count <= fail_count + 1;
            end else begin
               want_rsp = expected_q.pop_front();
               if (got_rsp.address !== want_rsp.address || got_rsp.status !== want_rsp.status
                   || got_rsp.free_bytes !== want_rsp.free_bytes
                   || got_rsp.min_free_bytes !== want_rsp.min_free_bytes) begin
                  if (fail_count < 10)
                     $display("mismatch: expected addr %0d st %0d free %0d min %0d, got addr %0d st %0d free %0d min %0d",
                        want_rsp.address, want_rsp.status, want_rsp.free_bytes,
                        want_rsp.min_free_bytes, got_rsp.address, got_rsp.status,
                        got_rsp.free_bytes, got_rsp.min_free_bytes);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            want_rsp = heap_response(req_item);
            expected_q.push_back(want_rsp);
            if (req_item.func == FUNC_ALLOC) begin
               if (want_rsp.status == STATUS_OK) ok_allocs <= ok_allocs + 1;
               else failed_allocs <= failed_allocs + 1;
            end else if (want_rsp.status == STATUS_OK) begin
               good_frees <= good_frees + 1;
            end else begin
               bad_frees <= bad_frees + 1;
            end
         end
      end
   end

endmodule

// File: tb/sv/first_fit_heap_allocator_top_tb.sv
`timescale 1ns / 100ps

module first_fit_heap_allocator_top_tb;
   import ffha_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      fail_count;
   int      pending_count;
   int      ok_allocs;
   int      failed_allocs;
   int      bad_frees;
   int      good_frees;
   int      cycle_count = 0;
   int      idle_pct = 0;
   logic [12:0] live_blocks[$];

   always #6 clock = ~clock;

   first_fit_heap_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   first_fit_heap_allocator_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .ok_allocs     (ok_allocs),
      .failed_allocs (failed_allocs),
      .bad_frees     (bad_frees),
      .good_frees    (good_frees)
   );

   // remember addresses handed out so frees can target live blocks
   always @(posedge clock) begin
      if (!reset && rsp_strobe && rsp_item.status == STATUS_OK && rsp_item.address != 0)
         live_blocks.push_back(rsp_item.address);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic issue(input func_type f, input logic [12:0] bytes, input logic [12:0] addr);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1'b1;
      req_item <= '{func: f, request_bytes: bytes, block_address: addr};
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic alloc_bytes(input logic [12:0] bytes);
      issue(FUNC_ALLOC, bytes, 13'($urandom));
   endtask

   task automatic free_addr(input logic [12:0] addr);
      issue(FUNC_FREE, 13'($urandom), addr);
   endtask

   task automatic wait_drained();
      while (pending_count != 0 || busy) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      int pick;
      int idx;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            if ($urandom_range(9) == 0) alloc_bytes(13'($urandom));
            else if ($urandom_range(4) == 0) alloc_bytes(13'($urandom_range(1, 1024)));
            else alloc_bytes(13'($urandom_range(1, 160)));
         end else if (pick < 85 && live_blocks.size() != 0) begin
            idx = $urandom_range(live_blocks.size() - 1);
            free_addr(live_blocks[idx]);
            live_blocks.delete(idx);
         end else if (pick < 92 && live_blocks.size() != 0) begin
            // interior or misaligned offset near a live block
            free_addr(live_blocks[$urandom_range(live_blocks.size() - 1)]
                      + 13'($urandom_range(1, 20)));
         end else begin
            free_addr(13'($urandom));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      alloc_bytes(13'd0);
      alloc_bytes(13'd8191);
      free_addr(13'd0);
      free_addr(13'd3);
      free_addr(13'd8191);
      free_addr(13'd8184);
      alloc_bytes(13'd1);
      alloc_bytes(13'd8);
      alloc_bytes(13'd9);
      alloc_bytes(13'd16);
      alloc_bytes(13'd24);
      wait_drained();
      free_addr(live_blocks[1]);
      free_addr(live_blocks[1]);
      free_addr(live_blocks[1] + 13'd8);
      free_addr(live_blocks[3]);
      free_addr(live_blocks[2]);
      alloc_bytes(13'd40);
      alloc_bytes(13'd7000);
      alloc_bytes(13'd4000);
      wait_drained();
      while (live_blocks.size() != 0) free_addr(live_blocks.pop_front());
      alloc_bytes(13'd8176);
      wait_drained();
      free_addr(live_blocks.pop_front());
      alloc_bytes(13'd8184);
      wait_drained();
      live_blocks.delete();
      free_addr(13'd8);

      idle_pct = 0;
      random_phase(500);
      idle_pct = 63;
      random_phase(450);
      wait_drained();
      repeat (20) @(posedge clock);
      idle_pct = 0;
      random_phase(450);
      idle_pct = 24;
      random_phase(450);

      wait_drained();
      repeat (40) @(posedge clock);
      $display("covered %0d good and %0d failed allocations, %0d frees and %0d rejected frees",
               ok_allocs, failed_allocs, good_frees, bad_frees);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: sim.f
design/ffha_pkg.sv
design/ffha_ram.sv
design/first_fit_heap_allocator_top.sv
design/ffha_checker.sv
tb/sv/first_fit_heap_allocator_checker.sv
tb/sv/first_fit_heap_allocator_top_tb.sv
